// ===== hw/rtl/htet_pkg.sv =====
package htet_pkg;

	// event kinds
	localparam logic [3:0] EV_TEXT     = 4'd0;
	localparam logic [3:0] EV_TEXT_END = 4'd1;
	localparam logic [3:0] EV_OPEN     = 4'd2;
	localparam logic [3:0] EV_CLOSE    = 4'd3;
	localparam logic [3:0] EV_TAGNAME  = 4'd4;
	localparam logic [3:0] EV_ATTRNAME = 4'd5;
	localparam logic [3:0] EV_VALUE    = 4'd6;
	localparam logic [3:0] EV_ATTR_END = 4'd7;
	localparam logic [3:0] EV_TAG_END  = 4'd8;
	localparam logic [3:0] EV_ERROR    = 4'd9;
	localparam logic [3:0] EV_DONE     = 4'd10;

	// entity surroundings
	localparam logic [1:0] CTX_TEXT     = 2'd0;
	localparam logic [1:0] CTX_QUOTED   = 2'd1;
	localparam logic [1:0] CTX_UNQUOTED = 2'd2;

	// entity radix
	localparam logic [1:0] RAD_NONE = 2'd0;
	localparam logic [1:0] RAD_DEC  = 2'd1;
	localparam logic [1:0] RAD_HEX  = 2'd2;

	localparam logic [21:0] CP_LIMIT = 22'h10FFFF;

	// one event
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data;
		logic       unk;
	} event_t;

	// a group of up to four events from one byte
	typedef struct packed {
		logic [2:0]      count;
		logic            last;
		event_t [3:0]    ev;
	} group_t;

	// parser modes
	typedef enum logic [18:0] {
		M_TEXT        = 19'h00001,
		M_TAG_OPEN    = 19'h00002,
		M_TAG_NAME    = 19'h00004,
		M_ATTR_SPACE  = 19'h00008,
		M_ATTR_NAME   = 19'h00010,
		M_ATTR_AFTER  = 19'h00020,
		M_VALUE_START = 19'h00040,
		M_QUOTED      = 19'h00080,
		M_UNQUOTED    = 19'h00100,
		M_CLOSE_PRE   = 19'h00200,
		M_CLOSE_NAME  = 19'h00400,
		M_CLOSE_TAIL  = 19'h00800,
		M_ENT_START   = 19'h01000,
		M_ENT_NAME    = 19'h02000,
		M_ENT_HASH    = 19'h04000,
		M_ENT_HEXPRE  = 19'h08000,
		M_ENT_DIGITS  = 19'h10000,
		M_ENT_TAIL    = 19'h20000,
		M_FAILED      = 19'h40000
	} mode_t;

endpackage

// ===== hw/rtl/htet_front.sv =====
// byte parser: consumes one byte a cycle while the queue has room, produces up to eight events as two groups
module htet_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	input  logic               in_eod,
	input  logic               space_ok,
	output logic               in_ready,
	output logic               push,
	output htet_pkg::group_t   grp_lo,
	output htet_pkg::group_t   grp_hi
);

	htet_pkg::mode_t mode_q;
	logic [1:0]  ctx_q;
	logic        quote_q;
	logic        close_q;
	logic [1:0]  rad_q;
	logic [21:0] acc_q;
	logic [3:0]  nm_q;
	logic        tpend_q;

	htet_pkg::mode_t md;
	logic [1:0]  ctx_d, rad_d;
	logic        quote_d, close_d, tpend_d;
	logic [21:0] acc_d;
	logic [3:0]  nm_d;
	htet_pkg::event_t [7:0] evs;
	logic [3:0]  n;

	function automatic logic blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction
	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic logic alnum(input logic [7:0] c);
		return digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction
	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction
	function automatic logic [4:0] hexv(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (digit(c)) r = {1'b0, c[3:0]};
		else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			r = {1'b0, c[3:0] + 4'd9};
		return r;
	endfunction

	assign in_ready = space_ok;
	wire fire = in_valid && in_ready;

	always_comb begin
		logic [7:0]  c;
		logic        again, eod, bad, nomatch;
		logic [3:0]  ek;
		logic [21:0] cp;
		logic [25:0] mul;
		logic [25:0] v;
		logic [4:0]  h;
		logic [7:0]  q;
		c = in_byte;
		eod = in_eod || c == 8'd0;
		md = mode_q; ctx_d = ctx_q; quote_d = quote_q; close_d = close_q;
		rad_d = rad_q; acc_d = acc_q; nm_d = nm_q; tpend_d = tpend_q;
		evs = '0; n = '0;
		again = 1'b1;
		bad = 1'b0; cp = '0; ek = '0; v = '0; h = '0; mul = '0;
		nomatch = 1'b0;
		q = quote_q ? 8'h27 : 8'h22;
		if (eod) begin
			again = 1'b0;
			if (mode_q != htet_pkg::M_FAILED) begin
				if (mode_q inside {htet_pkg::M_ENT_START, htet_pkg::M_ENT_NAME,
						htet_pkg::M_ENT_HASH, htet_pkg::M_ENT_HEXPRE,
						htet_pkg::M_ENT_DIGITS, htet_pkg::M_ENT_TAIL}
						&& ctx_q == htet_pkg::CTX_TEXT) begin
					if (mode_q != htet_pkg::M_ENT_TAIL) begin
						if (mode_q == htet_pkg::M_ENT_START) nomatch = 1'b1;
						// fall through to emit below
						md = htet_pkg::M_ENT_NAME;
						again = 1'b1;
					end else md = htet_pkg::M_TEXT;
				end
			end
		end
		// up to four passes over the byte
		for (int p = 0; p < 4; p++) begin
			if (again) begin
				logic endb;
				again = 1'b0;
				endb = 1'b0;
				case (md)
					htet_pkg::M_TEXT: begin
						if (c == "<") begin
							if (tpend_d) begin
								evs[n] = '{htet_pkg::EV_TEXT_END, 8'd0, 1'b0}; n = n + 4'd1;
							end
							tpend_d = 1'b0; md = htet_pkg::M_TAG_OPEN;
						end else if (c == "&") begin
							ctx_d = htet_pkg::CTX_TEXT; rad_d = htet_pkg::RAD_NONE;
							acc_d = '0; nm_d = '0; md = htet_pkg::M_ENT_START;
						end else begin
							evs[n] = '{htet_pkg::EV_TEXT, c, 1'b0}; n = n + 4'd1;
							tpend_d = 1'b1;
						end
					end
					htet_pkg::M_TAG_OPEN: begin
						if (blank(c)) begin
						end else if (c == "/") begin
							close_d = 1'b1;
							evs[n] = '{htet_pkg::EV_CLOSE, 8'd0, 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_CLOSE_PRE;
						end else begin
							close_d = 1'b0;
							evs[n] = '{htet_pkg::EV_OPEN, 8'd0, 1'b0}; n = n + 4'd1;
							if (alnum(c)) begin
								evs[n] = '{htet_pkg::EV_TAGNAME, lower(c), 1'b0};
								n = n + 4'd1; md = htet_pkg::M_TAG_NAME;
							end else begin
								md = htet_pkg::M_ATTR_SPACE; again = 1'b1;
							end
						end
					end
					htet_pkg::M_TAG_NAME: begin
						if (alnum(c)) begin
							evs[n] = '{htet_pkg::EV_TAGNAME, lower(c), 1'b0}; n = n + 4'd1;
						end else begin
							md = htet_pkg::M_ATTR_SPACE; again = 1'b1;
						end
					end
					htet_pkg::M_ATTR_SPACE: begin
						if (c == ">") begin
							evs[n] = '{htet_pkg::EV_TAG_END, 8'd0, 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_TEXT;
						end else if (alnum(c)) begin
							evs[n] = '{htet_pkg::EV_ATTRNAME, lower(c), 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_ATTR_NAME;
						end else if (c == "=") md = htet_pkg::M_VALUE_START;
					end
					htet_pkg::M_ATTR_NAME, htet_pkg::M_ATTR_AFTER: begin
						if (alnum(c)) begin
							if (md == htet_pkg::M_ATTR_AFTER) begin
								evs[n] = '{htet_pkg::EV_ATTR_END, 8'd0, 1'b0}; n = n + 4'd1;
								md = htet_pkg::M_ATTR_NAME;
							end
							evs[n] = '{htet_pkg::EV_ATTRNAME, lower(c), 1'b0}; n = n + 4'd1;
						end else if (blank(c)) md = htet_pkg::M_ATTR_AFTER;
						else if (c == "=") md = htet_pkg::M_VALUE_START;
						else begin
							evs[n] = '{htet_pkg::EV_ATTR_END, 8'd0, 1'b0}; n = n + 4'd1;
							if (c == ">") begin
								evs[n] = '{htet_pkg::EV_TAG_END, 8'd0, 1'b0}; n = n + 4'd1;
								md = htet_pkg::M_TEXT;
							end else md = htet_pkg::M_ATTR_SPACE;
						end
					end
					htet_pkg::M_VALUE_START: begin
						if (blank(c)) begin
						end else if (c == 8'h22 || c == 8'h27) begin
							quote_d = c == 8'h27; md = htet_pkg::M_QUOTED;
						end else begin
							md = htet_pkg::M_UNQUOTED; again = 1'b1;
						end
					end
					htet_pkg::M_QUOTED: begin
						if (c == q) begin
							evs[n] = '{htet_pkg::EV_ATTR_END, 8'd0, 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_ATTR_SPACE;
						end else if (c == "&") begin
							ctx_d = htet_pkg::CTX_QUOTED; rad_d = htet_pkg::RAD_NONE;
							acc_d = '0; nm_d = '0; md = htet_pkg::M_ENT_START;
						end else begin
							evs[n] = '{htet_pkg::EV_VALUE, c, 1'b0}; n = n + 4'd1;
						end
					end
					htet_pkg::M_UNQUOTED: begin
						if (c == ">") begin
							evs[n] = '{htet_pkg::EV_ATTR_END, 8'd0, 1'b0}; n = n + 4'd1;
							evs[n] = '{htet_pkg::EV_TAG_END, 8'd0, 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_TEXT;
						end else if (blank(c)) begin
							evs[n] = '{htet_pkg::EV_ATTR_END, 8'd0, 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_ATTR_SPACE;
						end else if (c == "&") begin
							ctx_d = htet_pkg::CTX_UNQUOTED; rad_d = htet_pkg::RAD_NONE;
							acc_d = '0; nm_d = '0; md = htet_pkg::M_ENT_START;
						end else begin
							evs[n] = '{htet_pkg::EV_VALUE, c, 1'b0}; n = n + 4'd1;
						end
					end
					htet_pkg::M_CLOSE_PRE, htet_pkg::M_CLOSE_NAME,
					htet_pkg::M_CLOSE_TAIL: begin
						if (c == ">") begin
							evs[n] = '{htet_pkg::EV_TAG_END, 8'd0, 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_TEXT;
						end else if (blank(c)) begin
							if (md == htet_pkg::M_CLOSE_NAME) md = htet_pkg::M_CLOSE_TAIL;
						end else if (alnum(c) && md != htet_pkg::M_CLOSE_TAIL) begin
							evs[n] = '{htet_pkg::EV_TAGNAME, lower(c), 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_CLOSE_NAME;
						end else begin
							evs[n] = '{htet_pkg::EV_ERROR, 8'd0, 1'b0}; n = n + 4'd1;
							md = htet_pkg::M_FAILED;
						end
					end
					htet_pkg::M_ENT_START: begin
						if (eod) begin
							nm_d = 4'd8; endb = 1'b1;
						end else if (blank(c)) begin
						end else if (c == "#") begin
							rad_d = htet_pkg::RAD_DEC; md = htet_pkg::M_ENT_HASH;
						end else if (alnum(c)) begin
							nomatch = 1'b1;
							md = htet_pkg::M_ENT_NAME;
						end else begin
							nm_d = 4'd8; endb = 1'b1;
						end
					end
					htet_pkg::M_ENT_NAME: begin
						if (!eod && alnum(c)) nomatch = 1'b1;
						else endb = 1'b1;
					end
					htet_pkg::M_ENT_HASH, htet_pkg::M_ENT_HEXPRE,
					htet_pkg::M_ENT_DIGITS: begin
						if (md == htet_pkg::M_ENT_DIGITS)
							h = (rad_d == htet_pkg::RAD_HEX) ? hexv(c)
								: (digit(c) ? {1'b0, c[3:0]} : 5'h10);
						else if (md == htet_pkg::M_ENT_HEXPRE) h = hexv(c);
						else h = digit(c) ? {1'b0, c[3:0]} : 5'h10;
						if (eod) endb = 1'b1;
						else if (md != htet_pkg::M_ENT_DIGITS && blank(c)) begin
						end else if (md == htet_pkg::M_ENT_HASH && c == "x") begin
							rad_d = htet_pkg::RAD_HEX; md = htet_pkg::M_ENT_HEXPRE;
						end else if (!h[4]) begin
							// full-width shift-add, then saturate past the code point range
							mul = (rad_d == htet_pkg::RAD_HEX) ? {acc_d, 4'd0}
								: {1'b0, acc_d, 3'd0} + {3'd0, acc_d, 1'b0};
							v = mul + {22'd0, h[3:0]};
							if (v > {4'd0, htet_pkg::CP_LIMIT})
								acc_d = htet_pkg::CP_LIMIT + 22'd1;
							else acc_d = v[21:0];
							md = htet_pkg::M_ENT_DIGITS;
						end else endb = 1'b1;
					end
					htet_pkg::M_ENT_TAIL: begin
						if (!blank(c)) begin
							md = (ctx_d == htet_pkg::CTX_QUOTED) ? htet_pkg::M_QUOTED :
								(ctx_d == htet_pkg::CTX_UNQUOTED) ? htet_pkg::M_UNQUOTED :
								htet_pkg::M_TEXT;
							again = c != ";";
						end
					end
					default: ;
				endcase
				// entity name matcher
				if (nomatch) begin
					logic [7:0] lc;
					lc = lower(c);
					nomatch = 1'b0;
					if (nm_d == 4'd0 && lc == "a") nm_d = 4'd1;
					else if (nm_d == 4'd0 && lc == "g") nm_d = 4'd4;
					else if (nm_d == 4'd0 && lc == "l") nm_d = 4'd6;
					else if (nm_d == 4'd1 && lc == "m") nm_d = 4'd2;
					else if (nm_d == 4'd2 && lc == "p") nm_d = 4'd3;
					else if (nm_d == 4'd4 && lc == "t") nm_d = 4'd5;
					else if (nm_d == 4'd6 && lc == "t") nm_d = 4'd7;
					else nm_d = 4'd8;
				end
				// entity emission, utf-8 encode
				if (endb) begin
					ek = (ctx_d == htet_pkg::CTX_TEXT) ? htet_pkg::EV_TEXT
						: htet_pkg::EV_VALUE;
					bad = 1'b0;
					if (rad_d == htet_pkg::RAD_NONE) begin
						case (nm_d)
							4'd3: cp = 22'h26;
							4'd5: cp = 22'h3E;
							4'd7: cp = 22'h3C;
							default: bad = 1'b1;
						endcase
					end else begin
						cp = acc_d;
						bad = cp == '0 || cp > htet_pkg::CP_LIMIT;
					end
					if (ek == htet_pkg::EV_TEXT) tpend_d = 1'b1;
					if (bad) begin
						evs[n] = '{ek, 8'h3F, 1'b1}; n = n + 4'd1;
					end else if (cp < 22'h80) begin
						evs[n] = '{ek, cp[7:0], 1'b0}; n = n + 4'd1;
					end else if (cp < 22'h800) begin
						evs[n] = '{ek, {3'b110, cp[10:6]}, 1'b0};
						evs[n + 4'd1] = '{ek, {2'b10, cp[5:0]}, 1'b0}; n = n + 4'd2;
					end else if (cp < 22'h10000) begin
						evs[n] = '{ek, {4'b1110, cp[15:12]}, 1'b0};
						evs[n + 4'd1] = '{ek, {2'b10, cp[11:6]}, 1'b0};
						evs[n + 4'd2] = '{ek, {2'b10, cp[5:0]}, 1'b0}; n = n + 4'd3;
					end else begin
						evs[n] = '{ek, {5'b11110, cp[20:18]}, 1'b0};
						evs[n + 4'd1] = '{ek, {2'b10, cp[17:12]}, 1'b0};
						evs[n + 4'd2] = '{ek, {2'b10, cp[11:6]}, 1'b0};
						evs[n + 4'd3] = '{ek, {2'b10, cp[5:0]}, 1'b0}; n = n + 4'd4;
					end
					rad_d = htet_pkg::RAD_NONE; acc_d = '0; nm_d = '0;
					if (eod) md = htet_pkg::M_TEXT;
					else if (blank(c)) md = htet_pkg::M_ENT_TAIL;
					else begin
						md = (ctx_d == htet_pkg::CTX_QUOTED) ? htet_pkg::M_QUOTED :
							(ctx_d == htet_pkg::CTX_UNQUOTED) ? htet_pkg::M_UNQUOTED :
							htet_pkg::M_TEXT;
						again = c != ";";
					end
				end
			end
		end
		// end of document tail
		if (eod) begin
			if (mode_q != htet_pkg::M_FAILED) begin
				if (md == htet_pkg::M_TEXT) begin
					if (tpend_d) begin
						evs[n] = '{htet_pkg::EV_TEXT_END, 8'd0, 1'b0}; n = n + 4'd1;
					end
					evs[n] = '{htet_pkg::EV_DONE, 8'd0, 1'b0}; n = n + 4'd1;
				end else begin
					evs[n] = '{htet_pkg::EV_ERROR, 8'd0, 1'b0}; n = n + 4'd1;
				end
			end
			md = htet_pkg::M_TEXT; ctx_d = htet_pkg::CTX_TEXT; quote_d = 1'b0;
			close_d = 1'b0; rad_d = htet_pkg::RAD_NONE; acc_d = '0; nm_d = '0;
			tpend_d = 1'b0;
		end
	end

	// split into two queue entries
	always_comb begin
		grp_lo.ev = evs[3:0];
		grp_hi.ev = evs[7:4];
		grp_lo.count = (n > 4'd4) ? 3'd4 : n[2:0];
		grp_hi.count = (n > 4'd4) ? 3'(n - 4'd4) : 3'd0;
		grp_lo.last = n <= 4'd4;
		grp_hi.last = 1'b1;
	end
	assign push = fire && n != 4'd0;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= htet_pkg::M_TEXT;
			ctx_q <= htet_pkg::CTX_TEXT;
			quote_q <= 1'b0;
			close_q <= 1'b0;
			rad_q <= htet_pkg::RAD_NONE;
			acc_q <= '0;
			nm_q <= '0;
			tpend_q <= 1'b0;
		end else if (fire) begin
			mode_q <= md;
			ctx_q <= ctx_d;
			quote_q <= quote_d;
			close_q <= close_d;
			rad_q <= rad_d;
			acc_q <= acc_d;
			nm_q <= nm_d;
			tpend_q <= tpend_d;
		end
	end

endmodule

// ===== hw/rtl/htet_back.sv =====
// event queue and serializer: stores groups of up to four events, one event out per beat
module htet_back #(
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  htet_pkg::group_t grp_lo,
	input  htet_pkg::group_t grp_hi,
	output logic             space_ok,
	output logic             out_valid,
	input  logic             out_ready,
	output htet_pkg::event_t out_ev,
	output logic             out_last
);

	localparam int AW = $clog2(DEPTH);

	htet_pkg::group_t [DEPTH-1:0] mem_q;
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic [1:0]    sub_q;

	htet_pkg::group_t head;
	logic two, pop, pop_grp;

	assign head = mem_q[rp_q];
	assign two = grp_hi.count != 3'd0;
	// space_ok only while the queue has room for two groups
	assign space_ok = cnt_q <= (AW + 1)'(DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_ev = head.ev[sub_q];
	assign out_last = head.last && (3'({1'b0, sub_q}) + 3'd1 == head.count);
	assign pop = out_valid && out_ready;
	assign pop_grp = pop && (3'({1'b0, sub_q}) + 3'd1 == head.count);

	// group storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= grp_lo;
			if (two) mem_q[AW'(wp_q + 1'b1)] <= grp_hi;
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			sub_q <= '0;
		end else begin
			if (push) wp_q <= AW'(wp_q + (two ? 2'd2 : 2'd1));
			if (pop_grp) begin
				rp_q <= AW'(rp_q + 1'b1);
				sub_q <= '0;
			end else if (pop) sub_q <= sub_q + 2'd1;
			cnt_q <= cnt_q + (push ? (two ? (AW + 1)'(2) : (AW + 1)'(1)) : '0)
				- (pop_grp ? (AW + 1)'(1) : '0);
		end
	end

endmodule

// ===== hw/rtl/html_tag_and_entity_tokenizer_top.sv =====
// html tag and entity tokenizer
// s_axis: one document byte per beat, tdata[7:0] = data_byte, tuser = end_of_document.
// a zero byte or tuser high ends the document and returns the parser to reset.
// m_axis: one token event per beat, tdata = event_kind[3:0], event_byte[11:4],
// tuser = unknown_entity, tlast marks the last event caused by one input byte.
// an input byte is parsed in the cycle it is taken; its events enter a group queue
// and leave it in order, one per cycle while m_axis_tready is high.
// input rate: one byte per cycle while the queue has room for two groups; a byte
// can raise up to eight events, and output drains one event per cycle when ready, so
// bursts slow input only when the queue of QUEUE_DEPTH groups nears full.
// bytes that give no event put nothing in the queue.
// reset empties the queue and puts the parser in text mode with no run open.
// when m_axis_tready is low, events hold and s_axis_tready drops once the queue
// nears full; no event is lost or repeated.
module html_tag_and_entity_tokenizer_top #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic        s_axis_tuser,  // end_of_document
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // event_kind[3:0], event_byte[11:4], zero fill
	output logic        m_axis_tuser,  // unknown_entity
	output logic        m_axis_tlast   // last_of_run
);

	htet_pkg::group_t grp_lo, grp_hi;
	htet_pkg::event_t ev;
	logic push, space_ok;

	htet_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_eod(s_axis_tuser),
		.space_ok(space_ok), .in_ready(s_axis_tready),
		.push(push), .grp_lo(grp_lo), .grp_hi(grp_hi)
	);

	htet_back #(.DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.push(push), .grp_lo(grp_lo), .grp_hi(grp_hi), .space_ok(space_ok),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_ev(ev), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, ev.data, ev.kind};
	assign m_axis_tuser = ev.unk;

`ifndef NO_ASSERTIONS
	// an unknown-entity flag only rides on a '?' byte
	a_unk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[11:4] == 8'h3F)
		else $error("unknown entity flag without substitute byte");
	// done always closes a run
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] == htet_pkg::EV_DONE |-> m_axis_tlast)
		else $error("done event not last of run");
	// no input taken when the queue cannot hold two groups
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space_ok)
		else $error("queue overflow");
`endif

endmodule

// ===== tb/tokenizer_checker.sv =====
module tokenizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          errors,
	output int          waiting
);

	typedef struct {
		logic [3:0] kind;
		logic [7:0] data;
		logic       unk;
		logic       last;
	} token_t;

	token_t byte_tokens[$];
	token_t expected_tokens[$];

	// shadow parser state
	htet_pkg::mode_t mode;
	logic [1:0]  ent_ctx;
	bit          quote_single;
	bit          close_tag;
	logic [1:0]  radix;
	int unsigned code_point;
	int unsigned name_state;
	bit          run_open;

	function automatic bit blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alnum(input logic [7:0] c);
		return alpha(c) || digit(c);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (digit(c)) return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	task automatic clear_state();
		mode = htet_pkg::M_TEXT;
		ent_ctx = htet_pkg::CTX_TEXT;
		quote_single = 0;
		close_tag = 0;
		radix = htet_pkg::RAD_NONE;
		code_point = 0;
		name_state = 0;
		run_open = 0;
	endtask

	task automatic emit(input logic [3:0] kind, input logic [7:0] data, input logic unk);
		token_t t;
		t.kind = kind;
		t.data = data;
		t.unk = unk;
		t.last = 0;
		if (byte_tokens.size() < 8) byte_tokens.push_back(t);
	endtask

	// match against amp, gt, lt
	task automatic name_step(input logic [7:0] c);
		int unsigned nxt;
		nxt = 8;
		if (name_state == 0 && c == "a") nxt = 1;
		else if (name_state == 0 && c == "g") nxt = 4;
		else if (name_state == 0 && c == "l") nxt = 6;
		else if (name_state == 1 && c == "m") nxt = 2;
		else if (name_state == 2 && c == "p") nxt = 3;
		else if (name_state == 4 && c == "t") nxt = 5;
		else if (name_state == 6 && c == "t") nxt = 7;
		name_state = nxt;
	endtask

	task automatic add_digit(input int unsigned d);
		longint unsigned v;
		longint unsigned lim;
		lim = longint'(htet_pkg::CP_LIMIT);
		v = longint'(code_point) * ((radix == htet_pkg::RAD_HEX) ? 16 : 10) + longint'(d);
		code_point = (v > lim) ? 32'(lim + 1) : 32'(v);
	endtask

	// decode entity into utf-8 bytes
	task automatic decode_entity();
		logic [3:0]  kind;
		int unsigned cp;
		bit          bad;
		kind = (ent_ctx == htet_pkg::CTX_TEXT) ? htet_pkg::EV_TEXT : htet_pkg::EV_VALUE;
		cp = 0;
		bad = 0;
		if (radix == htet_pkg::RAD_NONE) begin
			if (name_state == 3) cp = 32'h26;
			else if (name_state == 5) cp = 32'h3E;
			else if (name_state == 7) cp = 32'h3C;
			else bad = 1;
		end else begin
			cp = code_point;
			if (cp == 0 || cp > 32'(htet_pkg::CP_LIMIT)) bad = 1;
		end
		if (kind == htet_pkg::EV_TEXT) run_open = 1;
		if (bad) begin
			emit(kind, "?", 1);
		end else if (cp < 'h80) begin
			emit(kind, 8'(cp), 0);
		end else if (cp < 'h800) begin
			emit(kind, 8'(32'hC0 | (cp >> 6)), 0);
			emit(kind, 8'(32'h80 | (cp & 'h3F)), 0);
		end else if (cp < 'h10000) begin
			emit(kind, 8'(32'hE0 | (cp >> 12)), 0);
			emit(kind, 8'(32'h80 | ((cp >> 6) & 'h3F)), 0);
			emit(kind, 8'(32'h80 | (cp & 'h3F)), 0);
		end else begin
			emit(kind, 8'(32'hF0 | (cp >> 18)), 0);
			emit(kind, 8'(32'h80 | ((cp >> 12) & 'h3F)), 0);
			emit(kind, 8'(32'h80 | ((cp >> 6) & 'h3F)), 0);
			emit(kind, 8'(32'h80 | (cp & 'h3F)), 0);
		end
		radix = htet_pkg::RAD_NONE;
		code_point = 0;
		name_state = 0;
	endtask

	task automatic start_entity(input logic [1:0] ctx);
		ent_ctx = ctx;
		radix = htet_pkg::RAD_NONE;
		code_point = 0;
		name_state = 0;
		mode = htet_pkg::M_ENT_START;
	endtask

	task automatic exit_entity(input logic [7:0] c, output bit again);
		if (ent_ctx == htet_pkg::CTX_QUOTED) mode = htet_pkg::M_QUOTED;
		else if (ent_ctx == htet_pkg::CTX_UNQUOTED) mode = htet_pkg::M_UNQUOTED;
		else mode = htet_pkg::M_TEXT;
		again = (c != ";");
	endtask

	task automatic finish_entity(input logic [7:0] c, output bit again);
		decode_entity();
		if (blank(c)) begin
			mode = htet_pkg::M_ENT_TAIL;
			again = 0;
		end else begin
			exit_entity(c, again);
		end
	endtask

	// one pass over a byte; again set when the byte is seen again in the new mode
	task automatic parse_byte(input logic [7:0] c, output bit again);
		logic [7:0] q;
		int         h;
		q = quote_single ? 8'h27 : 8'h22;
		again = 0;
		case (mode)
			htet_pkg::M_TEXT: begin
				if (c == "<") begin
					if (run_open) emit(htet_pkg::EV_TEXT_END, 0, 0);
					run_open = 0;
					mode = htet_pkg::M_TAG_OPEN;
				end else if (c == "&") begin
					start_entity(htet_pkg::CTX_TEXT);
				end else begin
					emit(htet_pkg::EV_TEXT, c, 0);
					run_open = 1;
				end
			end
			htet_pkg::M_TAG_OPEN: begin
				if (blank(c)) begin
				end else if (c == "/") begin
					close_tag = 1;
					emit(htet_pkg::EV_CLOSE, 0, 0);
					mode = htet_pkg::M_CLOSE_PRE;
				end else begin
					close_tag = 0;
					emit(htet_pkg::EV_OPEN, 0, 0);
					if (alnum(c)) begin
						emit(htet_pkg::EV_TAGNAME, to_lower(c), 0);
						mode = htet_pkg::M_TAG_NAME;
					end else begin
						mode = htet_pkg::M_ATTR_SPACE;
						again = 1;
					end
				end
			end
			htet_pkg::M_TAG_NAME: begin
				if (alnum(c)) begin
					emit(htet_pkg::EV_TAGNAME, to_lower(c), 0);
				end else begin
					mode = htet_pkg::M_ATTR_SPACE;
					again = 1;
				end
			end
			htet_pkg::M_ATTR_SPACE: begin
				if (c == ">") begin
					emit(htet_pkg::EV_TAG_END, 0, 0);
					mode = htet_pkg::M_TEXT;
				end else if (alnum(c)) begin
					emit(htet_pkg::EV_ATTRNAME, to_lower(c), 0);
					mode = htet_pkg::M_ATTR_NAME;
				end else if (c == "=") begin
					mode = htet_pkg::M_VALUE_START;
				end
			end
			htet_pkg::M_ATTR_NAME, htet_pkg::M_ATTR_AFTER: begin
				if (alnum(c)) begin
					if (mode == htet_pkg::M_ATTR_AFTER) begin
						emit(htet_pkg::EV_ATTR_END, 0, 0);
						mode = htet_pkg::M_ATTR_NAME;
					end
					emit(htet_pkg::EV_ATTRNAME, to_lower(c), 0);
				end else if (blank(c)) begin
					mode = htet_pkg::M_ATTR_AFTER;
				end else if (c == "=") begin
					mode = htet_pkg::M_VALUE_START;
				end else begin
					emit(htet_pkg::EV_ATTR_END, 0, 0);
					if (c == ">") begin
						emit(htet_pkg::EV_TAG_END, 0, 0);
						mode = htet_pkg::M_TEXT;
					end else begin
						mode = htet_pkg::M_ATTR_SPACE;
					end
				end
			end
			htet_pkg::M_VALUE_START: begin
				if (blank(c)) begin
				end else if (c == 8'h22 || c == 8'h27) begin
					quote_single = (c == 8'h27);
					mode = htet_pkg::M_QUOTED;
				end else begin
					mode = htet_pkg::M_UNQUOTED;
					again = 1;
				end
			end
			htet_pkg::M_QUOTED: begin
				if (c == q) begin
					emit(htet_pkg::EV_ATTR_END, 0, 0);
					mode = htet_pkg::M_ATTR_SPACE;
				end else if (c == "&") begin
					start_entity(htet_pkg::CTX_QUOTED);
				end else begin
					emit(htet_pkg::EV_VALUE, c, 0);
				end
			end
			htet_pkg::M_UNQUOTED: begin
				if (c == ">") begin
					emit(htet_pkg::EV_ATTR_END, 0, 0);
					emit(htet_pkg::EV_TAG_END, 0, 0);
					mode = htet_pkg::M_TEXT;
				end else if (blank(c)) begin
					emit(htet_pkg::EV_ATTR_END, 0, 0);
					mode = htet_pkg::M_ATTR_SPACE;
				end else if (c == "&") begin
					start_entity(htet_pkg::CTX_UNQUOTED);
				end else begin
					emit(htet_pkg::EV_VALUE, c, 0);
				end
			end
			htet_pkg::M_CLOSE_PRE, htet_pkg::M_CLOSE_NAME, htet_pkg::M_CLOSE_TAIL: begin
				if (c == ">") begin
					emit(htet_pkg::EV_TAG_END, 0, 0);
					mode = htet_pkg::M_TEXT;
				end else if (blank(c)) begin
					if (mode == htet_pkg::M_CLOSE_NAME) mode = htet_pkg::M_CLOSE_TAIL;
				end else if (alnum(c) && mode != htet_pkg::M_CLOSE_TAIL) begin
					emit(htet_pkg::EV_TAGNAME, to_lower(c), 0);
					mode = htet_pkg::M_CLOSE_NAME;
				end else begin
					emit(htet_pkg::EV_ERROR, 0, 0);
					mode = htet_pkg::M_FAILED;
				end
			end
			htet_pkg::M_ENT_START: begin
				if (blank(c)) begin
				end else if (c == "#") begin
					radix = htet_pkg::RAD_DEC;
					mode = htet_pkg::M_ENT_HASH;
				end else if (alnum(c)) begin
					name_step(to_lower(c));
					mode = htet_pkg::M_ENT_NAME;
				end else begin
					name_state = 8;
					finish_entity(c, again);
				end
			end
			htet_pkg::M_ENT_NAME: begin
				if (alnum(c)) name_step(to_lower(c));
				else finish_entity(c, again);
			end
			htet_pkg::M_ENT_HASH: begin
				if (blank(c)) begin
				end else if (c == "x") begin
					radix = htet_pkg::RAD_HEX;
					mode = htet_pkg::M_ENT_HEXPRE;
				end else if (digit(c)) begin
					add_digit(32'(hex_digit(c)));
					mode = htet_pkg::M_ENT_DIGITS;
				end else begin
					finish_entity(c, again);
				end
			end
			htet_pkg::M_ENT_HEXPRE: begin
				h = hex_digit(c);
				if (blank(c)) begin
				end else if (h >= 0) begin
					add_digit(32'(h));
					mode = htet_pkg::M_ENT_DIGITS;
				end else begin
					finish_entity(c, again);
				end
			end
			htet_pkg::M_ENT_DIGITS: begin
				h = (radix == htet_pkg::RAD_HEX) ? hex_digit(c) : (digit(c) ? hex_digit(c) : -1);
				if (h >= 0) add_digit(32'(h));
				else finish_entity(c, again);
			end
			htet_pkg::M_ENT_TAIL: begin
				if (!blank(c)) exit_entity(c, again);
			end
			default: begin
			end
		endcase
	endtask

	// events caused by one input beat, queued as expectations
	task automatic predict_tokens(input logic [7:0] c, input logic eod);
		bit again;
		int pass;
		byte_tokens.delete();
		if (eod || c == 0) begin
			if (mode != htet_pkg::M_FAILED) begin
				if (mode inside {htet_pkg::M_ENT_START, htet_pkg::M_ENT_NAME,
						htet_pkg::M_ENT_HASH, htet_pkg::M_ENT_HEXPRE,
						htet_pkg::M_ENT_DIGITS, htet_pkg::M_ENT_TAIL}
						&& ent_ctx == htet_pkg::CTX_TEXT) begin
					if (mode != htet_pkg::M_ENT_TAIL) decode_entity();
					mode = htet_pkg::M_TEXT;
				end
				if (mode == htet_pkg::M_TEXT) begin
					if (run_open) emit(htet_pkg::EV_TEXT_END, 0, 0);
					emit(htet_pkg::EV_DONE, 0, 0);
				end else begin
					emit(htet_pkg::EV_ERROR, 0, 0);
				end
			end
			clear_state();
		end else begin
			for (pass = 0; pass < 4; pass++) begin
				parse_byte(c, again);
				if (!again) break;
			end
		end
		if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1;
		foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		token_t e;
		if (!arst_n) begin
			clear_state();
			expected_tokens.delete();
			errors <= 0;
			waiting <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected event tdata=%h tuser=%b tlast=%b", $time,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors <= errors + 1;
				end else begin
					e = expected_tokens.pop_front();
					if (m_axis_tdata !== {4'b0, e.data, e.kind} || m_axis_tuser !== e.unk ||
							m_axis_tlast !== e.last) begin
						$display("%0t: expected kind=%0d byte=%h unk=%b last=%b, got tdata=%h tuser=%b tlast=%b",
							$time, e.kind, e.data, e.unk, e.last, m_axis_tdata,
							m_axis_tuser, m_axis_tlast);
						errors <= errors + 1;
					end
				end
			end
			waiting <= expected_tokens.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	int          errors;
	int          waiting;
	int          bytes_sent;
	int          burst_left;
	int          stall_style;
	int          stall_count;

	html_tag_and_entity_tokenizer_top uut (.*);

	tokenizer_checker chk (.*);

	initial clk = 0;
	always #4 clk = ~clk;

	// receiver stall pattern, style picked at random each time the stall counter wraps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			stall_style <= 0;
			stall_count <= 0;
		end else begin
			stall_count <= (stall_count == 49) ? 0 : stall_count + 1;
			if (stall_count == 49) stall_style <= $urandom_range(0, 3);
			case (stall_style)
				0: m_axis_tready <= 1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (stall_count % 4 == 0);
				default: m_axis_tready <= (stall_count % 16 < 10);
			endcase
		end
	end

	// one input beat, bursts with random gaps
	task automatic send_beat(input logic [7:0] b, input logic eod);
		if (burst_left == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= b;
		s_axis_tuser <= eod;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i]) send_beat(s[i], 0);
	endtask

	task automatic end_doc();
		if ($urandom_range(0, 1)) send_beat(8'($urandom_range(0, 255)), 1);
		else send_beat(0, 0);
	endtask

	function automatic string rand_name(input int n);
		string cs;
		string s;
		int k;
		cs = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
		s = "";
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 61);
			s = {s, cs.substr(k, k)};
		end
		return s;
	endfunction

	function automatic string rand_blank();
		string bl;
		int k;
		bl = " \t\n\v\f\r";
		k = $urandom_range(0, 5);
		return ($urandom_range(0, 2) == 0) ? bl.substr(k, k) : "";
	endfunction

	function automatic string rand_entity();
		string s;
		string digs;
		case ($urandom_range(0, 7))
			0: s = "&amp";
			1: s = "&GT";
			2: s = "&lt";
			3: s = {"&", rand_name($urandom_range(0, 4))};
			4: s = $sformatf("&#%0d", $urandom_range(0, 1200000));
			5: s = $sformatf("&#%0d", $urandom_range(0, 3000));
			default: begin
				digs = $sformatf("%0h", $urandom_range(0, 'h11FFFF));
				if ($urandom_range(0, 1)) digs = digs.toupper();
				s = {"&#x", digs};
			end
		endcase
		case ($urandom_range(0, 3))
			0: s = {s, ";"};
			1: s = {s, rand_blank(), ";"};
			2: s = {s, " "};
			default: ;
		endcase
		return s;
	endfunction

	function automatic string rand_value();
		string s;
		s = "";
		for (int i = $urandom_range(0, 4); i > 0; i--)
			s = {s, ($urandom_range(0, 3) == 0) ? rand_entity() : rand_name(1)};
		return s;
	endfunction

	function automatic string rand_tag();
		string s;
		string n;
		if ($urandom_range(0, 3) == 0) begin
			// close tag, sometimes malformed
			s = {"</", rand_blank(), rand_name($urandom_range(1, 4)), rand_blank()};
			if ($urandom_range(0, 4) == 0) s = {s, ($urandom_range(0, 1) ? "x" : "/")};
			return {s, ">"};
		end
		s = {"<", rand_blank(), rand_name($urandom_range(0, 5))};
		for (int i = $urandom_range(0, 3); i > 0; i--) begin
			n = ($urandom_range(0, 7) == 0) ? "" : rand_name($urandom_range(1, 4));
			s = {s, " ", n, rand_blank()};
			case ($urandom_range(0, 4))
				0: ;
				1: s = {s, "=", rand_blank(), "\"", rand_value(), "'\""};
				2: s = {s, "='", rand_value(), "\"'"};
				3: s = {s, "=", rand_value()};
				default: s = {s, "/"};
			endcase
		end
		return {s, rand_blank(), ">"};
	endfunction

	// one random document, mostly well formed
	task automatic send_document();
		for (int i = $urandom_range(1, 6); i > 0; i--) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_text(rand_name($urandom_range(1, 5)));
				3, 4: send_text(rand_entity());
				5, 6, 7: send_text(rand_tag());
				8: send_beat(8'($urandom_range(1, 255)), 0);
				default: send_text(rand_blank());
			endcase
		end
		if ($urandom_range(0, 5) == 0) send_text("<p a=");
		end_doc();
	endtask

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		arst_n = 0;
		bytes_sent = 0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: named and numeric entities, odd tags, error cases
		send_text("a&amp;&gt &lt;&#65;&#x20ac;&#x1F600;&#0;&#99999999;&q;& ;&#;&");
		send_beat(0, 0);
		send_text("<A =\"&lt;\" b c=d&#xE9;>");
		send_beat(8'hFF, 1);
		send_text("<!x><</ b x>zz");
		send_beat(8'h00, 1);
		send_text("<p q=");
		send_beat(8'h55, 1);

		while (bytes_sent < 300) send_document();
		s_axis_tvalid <= 0;

		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
